### rtl/core/aip_pkg.sv
// ----------------------------------------------------------------------------
// aip_pkg
// Shared types, constants and character helpers of the integer text parser.
// ----------------------------------------------------------------------------
package aip_pkg;

  localparam logic [6:0] MaxDigits = 7'd64;

  localparam logic [1:0] CFG_BASE_MODE   = 2'd0;
  localparam logic [1:0] CFG_LIMIT_ON    = 2'd1;
  localparam logic [1:0] CFG_WIDTH_LIMIT = 2'd2;

  localparam logic [5:0] BaseAuto  = 6'd0;
  localparam logic [5:0] RadixBin  = 6'd2;
  localparam logic [5:0] RadixOct  = 6'd8;
  localparam logic [5:0] RadixDec  = 6'd10;
  localparam logic [5:0] RadixHex  = 6'd16;
  localparam logic [5:0] BaseReset = 6'd10;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpB   = 8'h42;
  localparam logic [7:0] ChLowB  = 8'h62;

  localparam logic [6:0] NoDigit = 7'd64;

  typedef enum logic [2:0] {
    PH_WS     = 3'd0,
    PH_SIGN   = 3'd1,
    PH_BASE   = 3'd2,
    PH_AUTOX  = 3'd3,
    PH_PREFIX = 3'd4,
    PH_HEXX   = 3'd5,
    PH_DIGITS = 3'd6,
    PH_DONE   = 3'd7
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic        negative;
    logic [5:0]  radix;
    logic [63:0] acc;
    logic [6:0]  digit_count;
    logic [15:0] consumed;
  } aip_state_t;

  typedef struct packed {
    logic [5:0]  base_mode;
    logic        limit_on;
    logic [15:0] width_limit;
  } aip_cfg_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Digits map to 0-9 and letters count from 10 up in either case; anything else maps to NoDigit.
  function automatic logic [6:0] digit_of(input logic [7:0] c);
    logic [6:0] d;
    d = NoDigit;
    if (c >= 8'h30 && c <= 8'h39) d = 7'(c - 8'd48);
    else if (c >= 8'h41 && c <= 8'h5A) d = 7'(c - 8'd55);
    else if (c >= 8'h61 && c <= 8'h7A) d = 7'(c - 8'd87);
    return d;
  endfunction

endpackage

### rtl/core/aip_cfg_regs.sv
// ----------------------------------------------------------------------------
// aip_cfg_regs
// Configuration register file written through the index/data write channel.
// ----------------------------------------------------------------------------
module aip_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output aip_pkg::aip_cfg_t cfg_o
);

  aip_pkg::aip_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        aip_pkg::CFG_BASE_MODE:   cfg_d.base_mode   = cfg_data_i[5:0];
        aip_pkg::CFG_LIMIT_ON:    cfg_d.limit_on    = cfg_data_i[0];
        aip_pkg::CFG_WIDTH_LIMIT: cfg_d.width_limit = cfg_data_i;
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_mode   <= aip_pkg::BaseReset;
      cfg_q.limit_on    <= 1'b0;
      cfg_q.width_limit <= 16'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/core/aip_step.sv
// ----------------------------------------------------------------------------
// aip_step
// Next-state logic for one text byte: walks the parse phases, consumes at most
// one byte and performs at most one multiply-add of the accumulator.
// ----------------------------------------------------------------------------
module aip_step (
  input  aip_pkg::aip_state_t state_i,
  input  aip_pkg::aip_cfg_t   cfg_i,
  input  logic [7:0]          ch_i,
  input  logic                eos_i,
  input  logic                start_i,
  output aip_pkg::aip_state_t state_o,
  output logic                taken_o,
  output logic                done_o,
  output logic [63:0]         value_o,
  output logic [15:0]         bytes_used_o
);

  always_comb begin
    aip_pkg::aip_state_t st;
    aip_pkg::aip_state_t nx;
    logic                ending;
    logic                took;
    logic                reject;
    logic                finish;
    logic [6:0]          dig;
    logic [63:0]         prod;

    st = state_i;
    if (start_i) begin
      st.phase       = aip_pkg::PH_WS;
      st.negative    = 1'b0;
      st.radix       = 6'd0;
      st.acc         = 64'd0;
      st.digit_count = 7'd0;
      st.consumed    = 16'd0;
    end

    ending = eos_i || (ch_i == aip_pkg::ChNul) ||
             (cfg_i.limit_on && (st.consumed >= cfg_i.width_limit));
    nx     = st;
    took   = 1'b0;
    reject = 1'b0;
    finish = 1'b0;
    dig    = aip_pkg::digit_of(ch_i);
    prod   = 64'd0;

    if (st.phase != aip_pkg::PH_DONE && !ending) begin
      if (nx.phase == aip_pkg::PH_WS) begin
        if (aip_pkg::is_space(ch_i)) took = 1'b1;
        else nx.phase = aip_pkg::PH_SIGN;
      end
      if (!took && nx.phase == aip_pkg::PH_SIGN) begin
        if (ch_i == aip_pkg::ChMinus) nx.negative = 1'b1;
        if (ch_i == aip_pkg::ChMinus || ch_i == aip_pkg::ChPlus) took = 1'b1;
        nx.phase = aip_pkg::PH_BASE;
      end
      if (!took && nx.phase == aip_pkg::PH_BASE) begin
        if (cfg_i.base_mode == aip_pkg::BaseAuto) begin
          if (ch_i == aip_pkg::ChZero) begin
            nx.radix = aip_pkg::RadixOct;
            took     = 1'b1;
            nx.phase = aip_pkg::PH_AUTOX;
          end else begin
            nx.radix = aip_pkg::RadixDec;
            nx.phase = aip_pkg::PH_PREFIX;
          end
        end else begin
          nx.radix = cfg_i.base_mode;
          nx.phase = aip_pkg::PH_PREFIX;
        end
      end
      if (!took && nx.phase == aip_pkg::PH_AUTOX) begin
        if (ch_i == aip_pkg::ChLowX || ch_i == aip_pkg::ChUpX) begin
          nx.radix = aip_pkg::RadixHex;
          took     = 1'b1;
        end else if (ch_i == aip_pkg::ChLowB || ch_i == aip_pkg::ChUpB) begin
          nx.radix = aip_pkg::RadixBin;
          took     = 1'b1;
        end
        nx.phase = aip_pkg::PH_PREFIX;
      end
      if (!took && nx.phase == aip_pkg::PH_PREFIX) begin
        if (ch_i == aip_pkg::ChZero && nx.radix == aip_pkg::RadixOct) begin
          took     = 1'b1;
          nx.phase = aip_pkg::PH_DIGITS;
        end else if (ch_i == aip_pkg::ChZero && nx.radix == aip_pkg::RadixHex) begin
          took     = 1'b1;
          nx.phase = aip_pkg::PH_HEXX;
        end else begin
          nx.phase = aip_pkg::PH_DIGITS;
        end
      end
      if (!took && nx.phase == aip_pkg::PH_HEXX) begin
        if (ch_i == aip_pkg::ChLowX || ch_i == aip_pkg::ChUpX) took = 1'b1;
        nx.phase = aip_pkg::PH_DIGITS;
      end
      if (!took && nx.phase == aip_pkg::PH_DIGITS) begin
        if (nx.digit_count >= aip_pkg::MaxDigits || dig[6] ||
            dig >= {1'b0, nx.radix}) begin
          reject = 1'b1;
        end else begin
          prod           = nx.acc * {58'd0, nx.radix};
          nx.acc         = prod + {57'd0, dig};
          nx.digit_count = nx.digit_count + 7'd1;
          took           = 1'b1;
        end
      end
    end

    if (took) begin
      if (nx.consumed != 16'hFFFF) nx.consumed = nx.consumed + 16'd1;
      finish = (cfg_i.limit_on && (nx.consumed >= cfg_i.width_limit)) ||
               (nx.phase == aip_pkg::PH_DIGITS &&
                nx.digit_count >= aip_pkg::MaxDigits);
    end

    done_o = (st.phase != aip_pkg::PH_DONE) && (ending || reject || finish);
    if (done_o) begin
      nx.phase = aip_pkg::PH_DONE;
      if (nx.negative) nx.acc = 64'd0 - nx.acc;
    end

    state_o      = nx;
    taken_o      = took;
    value_o      = done_o ? nx.acc : 64'd0;
    bytes_used_o = nx.consumed;
  end

endmodule

### rtl/core/ascii_integer_parser_core.sv
// An accepted byte waits in the input register; its result is registered when the output is free.
// Throughput: one byte per cycle while the output is free; the parse state loops through
// a single multiply-add by the radix between the input register and the result register.
// Reset: the parser restarts in the whitespace phase with a cleared accumulator,
// base_mode returns to 10 and the width limit is off.
// ----------------------------------------------------------------------------
// ascii_integer_parser_core
// Streaming signed integer parser with optional automatic radix detection.
// ----------------------------------------------------------------------------
module ascii_integer_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // ch
  input  logic        s_axis_tlast,  // eos
  input  logic        s_axis_tuser,  // start_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // value[63:0], bytes_used[79:64]
  output logic        m_axis_tlast,  // done_res
  output logic        m_axis_tuser   // taken
);

  aip_pkg::aip_cfg_t   cfg;
  aip_pkg::aip_state_t state_q, state_d;

  logic        in_valid_q;
  logic [7:0]  in_ch_q;
  logic        in_eos_q;
  logic        in_start_q;
  logic        out_valid_q;
  logic [79:0] out_data_q;
  logic        out_last_q;
  logic        out_user_q;
  logic        fire;
  logic        step_taken;
  logic        step_done;
  logic [63:0] step_value;
  logic [15:0] step_bytes;

  aip_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  aip_step u_step (
    .state_i      (state_q),
    .cfg_i        (cfg),
    .ch_i         (in_ch_q),
    .eos_i        (in_eos_q),
    .start_i      (in_start_q),
    .state_o      (state_d),
    .taken_o      (step_taken),
    .done_o       (step_done),
    .value_o      (step_value),
    .bytes_used_o (step_bytes)
  );

  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q          <= 1'b0;
      out_valid_q         <= 1'b0;
      state_q.phase       <= aip_pkg::PH_WS;
      state_q.negative    <= 1'b0;
      state_q.radix       <= 6'd0;
      state_q.acc         <= 64'd0;
      state_q.digit_count <= 7'd0;
      state_q.consumed    <= 16'd0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (fire) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_ch_q    <= s_axis_tdata;
      in_eos_q   <= s_axis_tlast;
      in_start_q <= s_axis_tuser;
    end
    if (fire) begin
      out_data_q <= {step_bytes, step_value};
      out_last_q <= step_done;
      out_user_q <= step_taken;
    end
  end

endmodule

### rtl/core/aip_checker.sv
// ----------------------------------------------------------------------------
// aip_checker
// Port-level checks of the integer text parser, bound to the top level.
// ----------------------------------------------------------------------------
module aip_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // A result that does not complete the number carries a zero value.
  a_value_zero_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[63:0] == 64'd0))
    else $error("value nonzero on a result that does not complete the number");

  // The input side only stalls when a result is waiting and blocked.
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while the output side was free");

  // A blocked result holds its contents until the transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
       $stable(m_axis_tuser)))
    else $error("stalled result changed before its transfer");

endmodule

bind ascii_integer_parser_core aip_checker u_aip_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

### verif/tb_ascii_integer_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascii_integer_parser_core
// Self-checking bench for the streaming integer text parser. Text bytes are
// pushed through the input stream while a behavioral parser, kept in step with
// every accepted transfer, predicts the result of each byte. Directed cases
// cover the edges of the grammar; random well-formed numbers, noise bytes and
// changing radix and width settings then run under varying flow control.
// ----------------------------------------------------------------------------
module tb_ascii_integer_parser_core;

  localparam logic [1:0] CfgSpare = 2'd3;
  localparam int unsigned HoldCycles = 240;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic        taken;
    logic        done;
    logic [63:0] value;
    logic [15:0] used;
  } parse_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  logic [5:0]  cfg_base = aip_pkg::BaseReset;
  logic        cfg_limit_on = 1'b0;
  logic [15:0] cfg_width = '0;

  aip_pkg::phase_e num_phase = aip_pkg::PH_WS;
  logic        num_neg = 1'b0;
  logic [5:0]  num_radix = '0;
  logic [63:0] num_acc = '0;
  logic [6:0]  num_digits = '0;
  logic [15:0] num_used = '0;

  parse_result_t pending_results[$];

  int unsigned src_idle = 0;
  int unsigned sink_stall = 0;
  logic        sink_hold = 1'b0;
  logic        open_start = 1'b0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned numbers_done = 0;
  int unsigned mismatches = 0;
  event        hold_ev;

  always #2 clk_i = ~clk_i;

  ascii_integer_parser_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  function automatic logic ws_byte(input logic [7:0] c);
    return c == 8'h20 || c inside {[8'h09:8'h0D]};
  endfunction

  function automatic logic [6:0] char_digit(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return 7'(c - aip_pkg::ChZero);
    if (c inside {[8'h41:8'h5A]}) return 7'(c - 8'h41 + 8'd10);
    if (c inside {[8'h61:8'h7A]}) return 7'(c - 8'h61 + 8'd10);
    return aip_pkg::NoDigit;
  endfunction

  function automatic logic limit_reached();
    return cfg_limit_on && num_used >= cfg_width;
  endfunction

  function automatic parse_result_t parse_byte(input logic [7:0] c, input logic eos,
                                               input logic st);
    parse_result_t r;
    logic          fin;
    logic          took;
    logic          stop;
    logic [6:0]    d;
    r = '0;
    if (st) begin
      num_phase  = aip_pkg::PH_WS;
      num_neg    = 1'b0;
      num_radix  = '0;
      num_acc    = '0;
      num_digits = '0;
      num_used   = '0;
    end
    fin = eos || c == aip_pkg::ChNul || limit_reached();
    stop = num_phase == aip_pkg::PH_DONE;
    while (!stop) begin
      took = 1'b0;
      case (num_phase)
        aip_pkg::PH_WS: begin
          if (fin) begin
            num_phase = aip_pkg::PH_DONE;
            r.done = 1'b1;
          end else if (ws_byte(c)) begin
            took = 1'b1;
          end else begin
            num_phase = aip_pkg::PH_SIGN;
          end
        end
        aip_pkg::PH_SIGN: begin
          if (!fin && c == aip_pkg::ChMinus) num_neg = 1'b1;
          if (!fin && (c == aip_pkg::ChMinus || c == aip_pkg::ChPlus)) took = 1'b1;
          num_phase = aip_pkg::PH_BASE;
        end
        aip_pkg::PH_BASE: begin
          if (cfg_base == aip_pkg::BaseAuto && !fin && c == aip_pkg::ChZero) begin
            num_radix = aip_pkg::RadixOct;
            took = 1'b1;
            num_phase = aip_pkg::PH_AUTOX;
          end else begin
            num_radix = (cfg_base == aip_pkg::BaseAuto) ? aip_pkg::RadixDec : cfg_base;
            num_phase = aip_pkg::PH_PREFIX;
          end
        end
        aip_pkg::PH_AUTOX: begin
          if (!fin && (c == aip_pkg::ChLowX || c == aip_pkg::ChUpX)) begin
            num_radix = aip_pkg::RadixHex;
            took = 1'b1;
          end else if (!fin && (c == aip_pkg::ChLowB || c == aip_pkg::ChUpB)) begin
            num_radix = aip_pkg::RadixBin;
            took = 1'b1;
          end
          num_phase = aip_pkg::PH_PREFIX;
        end
        aip_pkg::PH_PREFIX: begin
          if (!fin && c == aip_pkg::ChZero && num_radix == aip_pkg::RadixOct) begin
            took = 1'b1;
            num_phase = aip_pkg::PH_DIGITS;
          end else if (!fin && c == aip_pkg::ChZero && num_radix == aip_pkg::RadixHex) begin
            took = 1'b1;
            num_phase = aip_pkg::PH_HEXX;
          end else begin
            num_phase = aip_pkg::PH_DIGITS;
          end
        end
        aip_pkg::PH_HEXX: begin
          if (!fin && (c == aip_pkg::ChLowX || c == aip_pkg::ChUpX)) took = 1'b1;
          num_phase = aip_pkg::PH_DIGITS;
        end
        default: begin
          d = fin ? aip_pkg::NoDigit : char_digit(c);
          if (num_digits >= aip_pkg::MaxDigits || d >= aip_pkg::NoDigit ||
              d >= {1'b0, num_radix}) begin
            if (num_neg) num_acc = -num_acc;
            num_phase = aip_pkg::PH_DONE;
            r.done = 1'b1;
          end else begin
            num_acc = num_acc * num_radix + d;
            num_digits++;
            took = 1'b1;
          end
        end
      endcase
      if (took) begin
        r.taken = 1'b1;
        if (num_used != 16'hFFFF) num_used++;
        if (limit_reached()) fin = 1'b1;
        else if (!(num_phase == aip_pkg::PH_DIGITS && num_digits >= aip_pkg::MaxDigits))
          stop = 1'b1;
      end else if (num_phase == aip_pkg::PH_DONE) begin
        stop = 1'b1;
      end
    end
    r.value = r.done ? num_acc : '0;
    r.used = num_used;
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic eos, input logic st);
    if (src_idle != 0 && $urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= eos;
    s_axis_tuser  <= st;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(parse_byte(c, eos, st));
    items_sent++;
  endtask

  task automatic emit(input logic [7:0] c);
    send_byte(c, 1'b0, open_start);
    open_start = 1'b0;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) emit(s[i]);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      aip_pkg::CFG_BASE_MODE:   cfg_base = data[5:0];
      aip_pkg::CFG_LIMIT_ON:    cfg_limit_on = data[0];
      aip_pkg::CFG_WIDTH_LIMIT: cfg_width = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] ws_pick();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 5) ? 8'h20 : 8'(8'h09 + k);
  endfunction

  function automatic logic [7:0] x_pick();
    return $urandom_range(0, 1) ? aip_pkg::ChLowX : aip_pkg::ChUpX;
  endfunction

  function automatic logic [7:0] digit_pick(input logic [5:0] r);
    int unsigned top;
    int unsigned d;
    top = (r > 36) ? 35 : ((r == 0) ? 0 : r - 1);
    d = $urandom_range(0, top);
    if (d < 10) return 8'(aip_pkg::ChZero + d);
    return $urandom_range(0, 1) ? 8'(8'h41 + d - 10) : 8'(8'h61 + d - 10);
  endfunction

  task automatic send_number();
    logic [5:0]  r;
    int unsigned n;
    open_start = 1'b1;
    repeat ($urandom_range(0, 2)) emit(ws_pick());
    case ($urandom_range(0, 3))
      0: emit(aip_pkg::ChMinus);
      1: emit(aip_pkg::ChPlus);
      default: ;
    endcase
    r = cfg_base;
    if (cfg_base == aip_pkg::BaseAuto) begin
      r = aip_pkg::RadixDec;
      case ($urandom_range(0, 5))
        0: begin
          emit(aip_pkg::ChZero);
          emit(x_pick());
          r = aip_pkg::RadixHex;
        end
        1: begin
          emit(aip_pkg::ChZero);
          emit($urandom_range(0, 1) ? aip_pkg::ChLowB : aip_pkg::ChUpB);
          r = aip_pkg::RadixBin;
        end
        2: begin
          emit(aip_pkg::ChZero);
          r = aip_pkg::RadixOct;
        end
        default: ;
      endcase
    end
    if (r == aip_pkg::RadixHex && $urandom_range(0, 2) == 0) begin
      emit(aip_pkg::ChZero);
      if ($urandom_range(0, 1) != 0) emit(x_pick());
    end else if (r == aip_pkg::RadixOct && $urandom_range(0, 2) == 0) begin
      emit(aip_pkg::ChZero);
    end
    n = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 12);
    repeat (n) emit(digit_pick(r));
    case ($urandom_range(0, 4))
      0: emit(aip_pkg::ChNul);
      1: begin
        send_byte(8'($urandom), 1'b1, open_start);
        open_start = 1'b0;
      end
      2: emit(8'($urandom));
      3: emit(8'($urandom_range(32, 126)));
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) emit(8'($urandom));
  endtask

  task automatic random_config();
    logic [5:0]  b;
    logic [15:0] w;
    case ($urandom_range(0, 9))
      0, 1:    b = aip_pkg::BaseAuto;
      2:       b = aip_pkg::RadixDec;
      3:       b = aip_pkg::RadixHex;
      4:       b = aip_pkg::RadixOct;
      5:       b = aip_pkg::RadixBin;
      6:       b = 6'd36;
      7:       b = 6'd1;
      8:       b = 6'd63;
      default: b = 6'($urandom_range(0, 63));
    endcase
    case ($urandom_range(0, 3))
      0:       w = 16'($urandom_range(0, 10));
      1:       w = 16'($urandom_range(1, 25));
      2:       w = 16'($urandom);
      default: w = 16'hFFFF;
    endcase
    cfg_write(aip_pkg::CFG_BASE_MODE, {10'($urandom), b});
    cfg_write(aip_pkg::CFG_WIDTH_LIMIT, w);
    cfg_write(aip_pkg::CFG_LIMIT_ON, {15'($urandom), 1'($urandom_range(0, 2) == 0)});
  endtask

  task automatic test_no_start_after_reset();
    open_start = 1'b0;
    send_text(" -12");
    send_byte(8'h31, 1'b1, 1'b0);
    send_byte(8'h35, 1'b0, 1'b0);
  endtask

  task automatic test_end_cases();
    send_byte(aip_pkg::ChNul, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h80, 1'b0, 1'b1);
    send_byte(aip_pkg::ChPlus, 1'b0, 1'b1);
    send_byte(8'h7F, 1'b1, 1'b0);
  endtask

  task automatic test_auto_radix();
    drain();
    cfg_write(aip_pkg::CFG_BASE_MODE, 16'(aip_pkg::BaseAuto));
    open_start = 1'b1;
    send_text("0x0x1Fg");
    open_start = 1'b1;
    send_text("-0B1");
    emit(aip_pkg::ChNul);
    open_start = 1'b1;
    send_text("007 ");
  endtask

  task automatic test_width_limit();
    drain();
    cfg_write(aip_pkg::CFG_LIMIT_ON, 16'd1);
    cfg_write(aip_pkg::CFG_WIDTH_LIMIT, 16'd0);
    open_start = 1'b1;
    emit(8'h37);
    drain();
    cfg_write(aip_pkg::CFG_WIDTH_LIMIT, 16'd3);
    open_start = 1'b1;
    send_text(" -45");
    drain();
    cfg_write(aip_pkg::CFG_WIDTH_LIMIT, 16'hFFFF);
    cfg_write(aip_pkg::CFG_LIMIT_ON, 16'd0);
  endtask

  task automatic test_odd_radix();
    drain();
    cfg_write(aip_pkg::CFG_BASE_MODE, 16'hFFFF);
    open_start = 1'b1;
    send_text("zZ");
    emit(aip_pkg::ChNul);
    drain();
    cfg_write(aip_pkg::CFG_BASE_MODE, 16'd1);
    open_start = 1'b1;
    send_text("01");
    drain();
    cfg_write(CfgSpare, 16'h5A5A);
    cfg_write(aip_pkg::CFG_BASE_MODE, 16'(aip_pkg::RadixDec));
  endtask

  task automatic test_backpressure();
    int unsigned goal;
    drain();
    src_idle = 0;
    sink_stall <= 0;
    -> hold_ev;
    goal = items_sent + 40;
    while (items_sent < goal) send_number();
    drain();
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < 3; k++) begin
        drain();
        case (ph)
          0: begin
            src_idle = 0;
            sink_stall <= 0;
          end
          1: begin
            src_idle = 82;
            sink_stall <= 0;
          end
          2: begin
            src_idle = 0;
            sink_stall <= 82;
          end
          default: begin
            src_idle = 34;
            sink_stall <= 34;
          end
        endcase
        random_config();
        goal = items_sent + 100;
        while (items_sent < goal) begin
          if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3))
              send_byte(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
          end else begin
            send_number();
          end
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_stall);
  end

  initial forever begin
    @(hold_ev);
    sink_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    sink_hold <= 1'b0;
  end

  always @(posedge clk_i) begin : check_results
    parse_result_t got;
    parse_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tlast, m_axis_tdata[63:0], m_axis_tdata[79:64]};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result transfer: taken=%b done=%b value=%0d used=%0d",
                   got.taken, got.done, $signed(got.value), got.used);
      end else begin
        want = pending_results.pop_front();
        if (got.done) numbers_done++;
        if (got.taken !== want.taken || got.done !== want.done ||
            got.value !== want.value || got.used !== want.used) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("result %0d: expected taken=%b done=%b value=%0d used=%0d, %s",
                     results_seen, want.taken, want.done, $signed(want.value), want.used,
                     $sformatf("got taken=%b done=%b value=%0d used=%0d",
                               got.taken, got.done, $signed(got.value), got.used));
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_no_start_after_reset();
    test_end_cases();
    test_auto_radix();
    test_width_limit();
    test_odd_radix();
    test_backpressure();
    test_random_traffic();
    test_backpressure();
    drain();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d bytes and checked %0d results, %0d of them completed numbers,",
             items_sent, results_seen, numbers_done);
    $display("over auto, fixed and odd radices, width limits and mixed flow control.");
    if (mismatches == 0) begin
      $display("tb_ascii_integer_parser_core: PASS");
    end else begin
      $display("%0d mismatching transfers", mismatches);
      $display("tb_ascii_integer_parser_core: FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb_ascii_integer_parser_core: FAIL");
    $finish;
  end

endmodule
